@@ src/sdpm_pkg.sv @@
// ----------------------------------------------------------------------------
// sdpm_pkg
// Shared constants, command type and pixel math for the scale, dither and
// pack block.
// ----------------------------------------------------------------------------
`default_nettype none

package sdpm_pkg;

  localparam int SRC_WIDTH    = 160;
  localparam int SRC_HEIGHT   = 144;
  localparam int OUT_WIDTH_PX = (SRC_WIDTH * 3 + 1) / 2;
  localparam int ROW_BYTES    = (OUT_WIDTH_PX + 7) / 8;

  localparam int COL_W = $clog2(SRC_WIDTH);
  localparam int ROW_W = $clog2(SRC_HEIGHT);
  localparam int AW    = $clog2(ROW_BYTES);
  localparam int IDX_W = $clog2(ROW_BYTES + 1);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [3:0] BAYER [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  // bytes closed by one pixel, in output order
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] dup0;
    logic [7:0] byte1;
    logic [7:0] dup1;
    logic       two;
    logic       row_end;
    logic       even_row;
    logic       eof;
  } sdpm_cmd_t;

  function automatic logic [7:0] bayer_thr(input logic [1:0] y, input logic [1:0] x);
    return {BAYER[{y, x}], 4'h8};
  endfunction

  function automatic logic [7:0] luma(input logic [14:0] p);
    logic [12:0] sum;
    sum = 13'(p[14:10]) * 13'd77 + 13'(p[9:5]) * 13'd151 + 13'(p[4:0]) * 13'd28;
    return sum[12:5];
  endfunction

endpackage

`default_nettype wire

@@ src/sdpm_front.sv @@
// ----------------------------------------------------------------------------
// sdpm_front
// Takes source pixels, dithers the one or two output pixels of each for one
// or both rows, packs bits and issues a command for every closed byte group.
// ----------------------------------------------------------------------------
`default_nettype none

module sdpm_front import sdpm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [14:0] pixel,
  input  wire logic        q_full,
  output logic             q_push,
  output sdpm_cmd_t        q_cmd
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [7:0]       main_r, main_nxt;
  logic [7:0]       dup_r, dup_nxt;
  logic [2:0]       cnt_r, cnt_nxt;

  logic             accept;
  logic [7:0]       lum;
  logic             even_col, even_row, row_end, frame_end;
  logic [COL_W+1:0] bx_full;
  logic [ROW_W+1:0] by_full;
  logic [1:0]       bx, bx1, by, by1;
  logic             dm0, dm1, dd0, dd1;
  logic [7:0]       mask0, mask1, m1, u1, m2, u2;
  logic [3:0]       cnt1, cnt2;
  logic             close_loop;
  logic [7:0]       cl_byte, cl_dup;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !q_full;

  always_comb begin
    lum       = luma(pixel);
    even_col  = !col_r[0];
    even_row  = !row_r[0];
    row_end   = (col_r == COL_W'(SRC_WIDTH - 1));
    frame_end = row_end && (row_r == ROW_W'(SRC_HEIGHT - 1));
    bx_full   = {1'b0, col_r, 1'b0} + {2'b00, col_r} + (COL_W+2)'(1);
    by_full   = {1'b0, row_r, 1'b0} + {2'b00, row_r} + (ROW_W+2)'(1);
    bx        = bx_full[2:1];
    by        = by_full[2:1];
    bx1       = bx + 2'd1;
    by1       = by + 2'd1;
    dm0       = lum < bayer_thr(by, bx);
    dm1       = lum < bayer_thr(by, bx1);
    dd0       = even_row && (lum < bayer_thr(by1, bx));
    dd1       = even_row && (lum < bayer_thr(by1, bx1));

    close_loop = 1'b0;
    cl_byte    = 8'd0;
    cl_dup     = 8'd0;

    // first output pixel
    mask0 = 8'h80 >> cnt_r;
    m1    = main_r | (dm0 ? mask0 : 8'd0);
    u1    = dup_r | (dd0 ? mask0 : 8'd0);
    cnt1  = {1'b0, cnt_r} + 4'd1;
    if (cnt1 == 4'd8) begin
      close_loop = 1'b1;
      cl_byte    = m1;
      cl_dup     = u1;
      m1         = 8'd0;
      u1         = 8'd0;
      cnt1       = 4'd0;
    end

    // doubled pixel of an even column
    mask1 = 8'h80 >> cnt1[2:0];
    m2    = m1;
    u2    = u1;
    cnt2  = cnt1;
    if (even_col) begin
      m2   = m1 | (dm1 ? mask1 : 8'd0);
      u2   = u1 | (dd1 ? mask1 : 8'd0);
      cnt2 = cnt1 + 4'd1;
      if (cnt2 == 4'd8) begin
        close_loop = 1'b1;
        cl_byte    = m2;
        cl_dup     = u2;
        m2         = 8'd0;
        u2         = 8'd0;
        cnt2       = 4'd0;
      end
    end

    q_cmd          = '0;
    q_cmd.row_end  = row_end;
    q_cmd.even_row = even_row;
    q_cmd.eof      = frame_end;
    if (close_loop) begin
      q_cmd.byte0 = cl_byte;
      q_cmd.dup0  = cl_dup;
      q_cmd.byte1 = m2;
      q_cmd.dup1  = u2;
      q_cmd.two   = row_end && (cnt2 != 4'd0);
    end else begin
      q_cmd.byte0 = m2;
      q_cmd.dup0  = u2;
    end
    q_push = accept && (close_loop || row_end);

    col_nxt  = col_r + COL_W'(1);
    row_nxt  = row_r;
    main_nxt = m2;
    dup_nxt  = u2;
    cnt_nxt  = cnt2[2:0];
    if (row_end) begin
      col_nxt  = '0;
      row_nxt  = frame_end ? '0 : row_r + ROW_W'(1);
      main_nxt = 8'd0;
      dup_nxt  = 8'd0;
      cnt_nxt  = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      main_r <= 8'd0;
      dup_r  <= 8'd0;
      cnt_r  <= 3'd0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      main_r <= main_nxt;
      dup_r  <= dup_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(SRC_WIDTH - 1))
    else $error("column past row end");
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_W'(SRC_HEIGHT - 1))
    else $error("row past frame end");
  a_row_end_push: assert property (@(posedge clk) disable iff (!rst_n)
    accept && row_end |-> q_push)
    else $error("row end without command");
`endif

endmodule

`default_nettype wire

@@ src/sdpm_queue.sv @@
// ----------------------------------------------------------------------------
// sdpm_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sdpm_queue import sdpm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire sdpm_cmd_t push_cmd,
  output logic           full,
  input  wire logic      pop,
  output sdpm_cmd_t      pop_cmd,
  output logic           empty
);

  sdpm_cmd_t      slot_r [QDEPTH];
  logic [QAW:0]   wr_ptr_r, rd_ptr_r;

  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (wr_ptr_r[QAW-1:0] == rd_ptr_r[QAW-1:0]) && (wr_ptr_r[QAW] != rd_ptr_r[QAW]);
  assign pop_cmd = slot_r[rd_ptr_r[QAW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r[QAW-1:0]] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + (QAW+1)'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + (QAW+1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) <= (QAW+1)'(QDEPTH))
    else $error("queue fill out of range");
`endif

endmodule

`default_nettype wire

@@ src/sdpm_back.sv @@
// ----------------------------------------------------------------------------
// sdpm_back
// Sends the bytes of each command, keeps the duplicate row in a byte store
// and sends that store whole at the end of an even source row.
// ----------------------------------------------------------------------------
`default_nettype none

module sdpm_back import sdpm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_empty,
  input  wire sdpm_cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  output logic [7:0]     out_byte,
  output logic           out_last,
  output logic           out_eof
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAIN,
    S_FLUSH_RD,
    S_FLUSH
  } state_t;

  state_t           state_r;
  sdpm_cmd_t        cmd_r;
  logic             sel_r;
  logic [IDX_W-1:0] wr_idx_r;
  logic [AW-1:0]    rd_addr_r;
  logic [7:0]       rd_data_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             out_eof_r;

  logic [7:0]       mem [ROW_BYTES];

  logic             out_free;
  logic             last_main;
  logic             flush;
  logic             we;
  logic             load;
  logic [7:0]       wdata;

  assign out_free   = !out_valid_r || out_tready;
  assign last_main  = !cmd_r.two || sel_r;
  assign flush      = cmd_r.row_end && cmd_r.even_row;
  assign we         = (state_r == S_MAIN) && out_free && cmd_r.even_row;
  assign load       = out_free && ((state_r == S_MAIN) || (state_r == S_FLUSH));
  assign wdata      = sel_r ? cmd_r.dup1 : cmd_r.dup0;
  assign q_pop      = (state_r == S_IDLE) && !q_empty;
  assign out_tvalid = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_eof    = out_eof_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_idx_r[AW-1:0]] <= wdata;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= 1'b0;
      wr_idx_r    <= '0;
      rd_addr_r   <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_eof_r   <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r   <= q_cmd;
            sel_r   <= 1'b0;
            state_r <= S_MAIN;
          end
        end
        S_MAIN: begin
          if (out_free) begin
            out_byte_r  <= sel_r ? cmd_r.byte1 : cmd_r.byte0;
            out_last_r  <= last_main && !flush;
            out_eof_r   <= last_main && !flush && cmd_r.eof;
            if (last_main && cmd_r.row_end) begin
              wr_idx_r <= '0;
            end else if (cmd_r.even_row) begin
              wr_idx_r <= wr_idx_r + IDX_W'(1);
            end
            if (!last_main) begin
              sel_r <= 1'b1;
            end else begin
              if (flush) begin
                rd_addr_r <= '0;
                state_r   <= S_FLUSH_RD;
              end else begin
                state_r <= S_IDLE;
              end
            end
          end
        end
        S_FLUSH_RD: begin
          state_r <= S_FLUSH;
        end
        S_FLUSH: begin
          if (out_free) begin
            out_byte_r  <= rd_data_r;
            out_last_r  <= (rd_addr_r == AW'(ROW_BYTES - 1));
            out_eof_r   <= (rd_addr_r == AW'(ROW_BYTES - 1)) && cmd_r.eof;
            if (rd_addr_r == AW'(ROW_BYTES - 1)) begin
              state_r <= S_IDLE;
            end else begin
              rd_addr_r <= rd_addr_r + AW'(1);
              state_r   <= S_FLUSH_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_eof_r |-> out_last_r)
    else $error("frame end on a byte that is not last");
  a_wr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_idx_r <= IDX_W'(ROW_BYTES))
    else $error("row store index out of range");
  a_flush_after_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH_RD) && (rd_addr_r == '0) |-> (wr_idx_r == '0))
    else $error("flush started with row index not cleared");
  a_busy_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !q_pop)
    else $error("command taken while busy");
`endif

endmodule

`default_nettype wire

@@ src/scale_dither_pack_mono.sv @@
// ----------------------------------------------------------------------------
// scale_dither_pack_mono
// 1.5x nearest neighbour upscale, 4x4 ordered dither and msb-first packing
// of an rgb555 frame into a 1-bit picture, 30 bytes per output row.
// ----------------------------------------------------------------------------
// channel   dir   tdata                     tlast          tuser
// in_       in    [14:0] pixel_rgb555       -              -
// out_      out   [7:0] mono_byte           last_of_run    end_of_frame
//
// the front takes one pixel per cycle while the command queue has room
// the back takes a new command only once all bytes of the last are sent
// the duplicate row flush reads each stored byte in S_FLUSH_RD, sends it in
// S_FLUSH, and the input stalls once the queue fills meanwhile
// rst_n is synchronous; the row store is not cleared and needs no sweep
// the output register frees the back as soon as a byte is taken
// ----------------------------------------------------------------------------
`default_nettype none

module scale_dither_pack_mono import sdpm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [14:0] pixel_rgb555
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] mono_byte
  output logic             out_tlast,
  output logic             out_tuser   // [0] end_of_frame
);

  sdpm_cmd_t push_cmd;
  sdpm_cmd_t pop_cmd;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  sdpm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .pixel     (in_tdata[14:0]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  sdpm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  sdpm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .out_eof    (out_tuser)
  );

endmodule

`default_nettype wire

@@ tb/tb_scale_dither_pack_mono.sv @@
// ----------------------------------------------------------------------------
// tb_scale_dither_pack_mono
// Self-checking bench for the 1.5x upscale, ordered dither and byte packer.
// A short table of pixels opens the run, with fixed bytes for the all-dark and
// all-light extremes. Random pixels then run past the end of the first source
// row, so the row end, the duplicate row flush and the start of an odd row
// are covered. The two fixed bytes are checked as given, all other bytes
// against an in-bench model of the scaler and ditherer, with random stalls
// on both streams, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_scale_dither_pack_mono;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SRC_W        = sdpm_pkg::SRC_WIDTH;
  localparam int SRC_H        = sdpm_pkg::SRC_HEIGHT;
  localparam int ROW_BYTES    = sdpm_pkg::ROW_BYTES;
  localparam int TOTAL_ITEMS  = SRC_W + 5;
  localparam int DIR_ROWS     = 21;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_SHOWN    = 50;

  localparam int DITHER_RANK [16] = '{
    0, 8, 2, 10,
    12, 4, 14, 6,
    3, 11, 1, 9,
    15, 7, 13, 5
  };

  typedef struct packed {
    logic [7:0] mono;
    logic       last;
    logic       eof;
  } mono_exp_t;

  typedef struct packed {
    logic [14:0] px;
    logic        fixed;
    logic        has_byte;
    logic [7:0]  mono;
  } dir_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [15:0] in_tdata   = 16'h0000;
  logic        out_tready = 1'b0;
  wire logic       in_tready;
  wire logic       out_tvalid;
  wire logic [7:0] out_tdata;
  wire logic       out_tlast;
  wire logic       out_tuser;

  mono_exp_t expected_bytes[$];
  mono_exp_t pixel_bytes[$];
  int        err_count  = 0;
  int        idle_phase = 0;
  bit        hold_req   = 1'b0;

  int         col_pos;
  int         row_pos;
  logic [7:0] main_acc;
  logic [7:0] dup_acc;
  int         bit_pos;
  logic [7:0] dup_row [ROW_BYTES];

  // starts at row 0 column 0: five black pixels close one dark byte,
  // six white pixels close one light byte, then table rows for the model
  dir_row_t directed_rows [DIR_ROWS] = '{
    {15'h0000, 1'b1, 1'b0, 8'h00},
    {15'h0000, 1'b1, 1'b0, 8'h00},
    {15'h0000, 1'b1, 1'b0, 8'h00},
    {15'h0000, 1'b1, 1'b0, 8'h00},
    {15'h0000, 1'b1, 1'b1, 8'hff},
    {15'h7fff, 1'b1, 1'b0, 8'h00},
    {15'h7fff, 1'b1, 1'b0, 8'h00},
    {15'h7fff, 1'b1, 1'b0, 8'h00},
    {15'h7fff, 1'b1, 1'b0, 8'h00},
    {15'h7fff, 1'b1, 1'b0, 8'h00},
    {15'h7fff, 1'b1, 1'b1, 8'h00},
    {15'h7c00, 1'b0, 1'b0, 8'h00},
    {15'h03e0, 1'b0, 1'b0, 8'h00},
    {15'h001f, 1'b0, 1'b0, 8'h00},
    {15'h7ffe, 1'b0, 1'b0, 8'h00},
    {15'h0001, 1'b0, 1'b0, 8'h00},
    {15'h5555, 1'b0, 1'b0, 8'h00},
    {15'h2aaa, 1'b0, 1'b0, 8'h00},
    {15'h4210, 1'b0, 1'b0, 8'h00},
    {15'h3def, 1'b0, 1'b0, 8'h00},
    {15'h7bde, 1'b0, 1'b0, 8'h00}
  };

  scale_dither_pack_mono i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [14:0] pixel_rgb555
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] mono_byte
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)   // [0] end_of_frame
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("tb_scale_dither_pack_mono: errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_SHOWN) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  function automatic bit is_dark(input int lum, input int x, input int y);
    return lum < DITHER_RANK[(y % 4) * 4 + (x % 4)] * 16 + 8;
  endfunction

  function automatic void close_byte(input int idx, input bit even_row);
    pixel_bytes.push_back({main_acc, 2'b00});
    if (even_row && idx < ROW_BYTES) begin
      dup_row[idx] = dup_acc;
    end
    main_acc = 8'h00;
    dup_acc  = 8'h00;
    bit_pos  = 0;
  endfunction

  function automatic void clear_model();
    col_pos  = 0;
    row_pos  = 0;
    main_acc = 8'h00;
    dup_acc  = 8'h00;
    bit_pos  = 0;
    for (int i = 0; i < ROW_BYTES; i++) begin
      dup_row[i] = 8'h00;
    end
  endfunction

  task automatic predict_mono_bytes(input logic [14:0] px);
    int         lum;
    int         base_x;
    int         base_y;
    int         reps;
    int         x;
    int         n;
    bit         even_row;
    bit         row_end;
    bit         frame_end;
    logic [7:0] mask;
    mono_exp_t  tail;
    pixel_bytes.delete();
    lum       = (int'(px[14:10]) * 77 + int'(px[9:5]) * 151 + int'(px[4:0]) * 28) >> 5;
    even_row  = (row_pos % 2) == 0;
    base_x    = (3 * col_pos + 1) / 2;
    base_y    = (3 * row_pos + 1) / 2;
    reps      = ((col_pos % 2) == 0) ? 2 : 1;
    row_end   = col_pos >= SRC_W - 1;
    frame_end = row_end && row_pos >= SRC_H - 1;
    x = base_x;
    for (int k = 0; k < reps; k++) begin
      x    = base_x + k;
      mask = 8'h80 >> bit_pos;
      if (is_dark(lum, x, base_y)) main_acc = main_acc | mask;
      if (even_row && is_dark(lum, x, base_y + 1)) dup_acc = dup_acc | mask;
      bit_pos++;
      if (bit_pos >= 8) close_byte(x >> 3, even_row);
    end
    if (row_end) begin
      if (bit_pos != 0) close_byte(x >> 3, even_row);
      if (even_row) begin
        for (int i = 0; i < ROW_BYTES; i++) begin
          pixel_bytes.push_back({dup_row[i], 2'b00});
        end
      end
      main_acc = 8'h00;
      dup_acc  = 8'h00;
      bit_pos  = 0;
      col_pos  = 0;
      row_pos  = (row_pos >= SRC_H - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    n = pixel_bytes.size();
    if (n > 0) begin
      tail      = pixel_bytes[n - 1];
      tail.last = 1'b1;
      tail.eof  = frame_end;
      pixel_bytes[n - 1] = tail;
    end
  endtask

  task automatic queue_prediction();
    foreach (pixel_bytes[j]) begin
      expected_bytes.push_back(pixel_bytes[j]);
    end
  endtask

  function automatic logic [14:0] next_pixel();
    logic [4:0] v;
    v = 5'($urandom_range(0, 31));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 15'($urandom_range(0, 32767));
      4, 5, 6:    return {v, v, v};
      7:          return ($urandom_range(0, 1) == 0) ? 15'h0000 : 15'h7fff;
      8: begin
        case ($urandom_range(0, 2))
          0:       return {v, 10'h000};
          1:       return {5'h00, v, 5'h00};
          default: return {10'h000, v};
        endcase
      end
      default:    return {v, 5'($urandom_range(0, 31)), v};
    endcase
  endfunction

  // one pixel request per call, returns at the accepting edge
  task automatic send_pixel(input logic [14:0] px);
    int pct;
    pct = (idle_phase == 0) ? 20 : (idle_phase == 1) ? 70 : 0;
    while ($urandom_range(0, 99) < pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, px};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  initial begin
    int pct;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        pct = (idle_phase == 0) ? 70 : (idle_phase == 1) ? 20 : 0;
        out_tready <= ($urandom_range(0, 99) >= pct);
      end
    end
  end

  always @(posedge clk) begin
    mono_exp_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h with nothing expected", out_tdata));
      end else begin
        e = expected_bytes.pop_front();
        if (out_tdata !== e.mono) begin
          report_mismatch($sformatf("mono_byte %02h, want %02h", out_tdata, e.mono));
        end
        if (out_tlast !== e.last) begin
          report_mismatch($sformatf("last_of_run %b, want %b", out_tlast, e.last));
        end
        if (out_tuser !== e.eof) begin
          report_mismatch($sformatf("end_of_frame %b, want %b", out_tuser, e.eof));
        end
      end
    end
  end

  initial begin
    logic [14:0] px;
    clear_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_pixel(directed_rows[i].px);
      predict_mono_bytes(directed_rows[i].px);
      if (directed_rows[i].fixed) begin
        if (directed_rows[i].has_byte) begin
          expected_bytes.push_back({directed_rows[i].mono, 2'b10});
        end
      end else begin
        queue_prediction();
      end
    end
    wait_drained();

    for (int n = DIR_ROWS; n < TOTAL_ITEMS; n++) begin
      if (n == TOTAL_ITEMS / 3) begin
        idle_phase = 1;
        wait_drained();
      end
      if (n == 2 * TOTAL_ITEMS / 3) begin
        idle_phase = 2;
        hold_req   = 1'b1;
      end
      px = next_pixel();
      send_pixel(px);
      predict_mono_bytes(px);
      queue_prediction();
    end
    in_tvalid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
    end
    if (err_count == 0) begin
      $display("tb_scale_dither_pack_mono: clean");
    end else begin
      $display("tb_scale_dither_pack_mono: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
